// ===== rtl/core/yuv_box_nearest_color_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// YUV box classifier assertion macros
// Shared concurrent assertion forms for the classifier checkers.
// ----------------------------------------------------------------------------
`ifndef YUV_BOX_NEAREST_COLOR_CLASSIFIER_MACROS_SVH
`define YUV_BOX_NEAREST_COLOR_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define YUVB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define YUVB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, live through reset.
`define YUVB_ASSERT_NXT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/yuvb_pkg.sv =====
// ----------------------------------------------------------------------------
// YUV box classifier package
// Types, constants and codes shared by the classifier modules.
// ----------------------------------------------------------------------------
package yuvb_pkg;

    localparam int NUM_COLORS_DEF  = 10;
    localparam int SAMPLE_STEP_DEF = 10;

    localparam int ENTRY_W = 4;
    localparam int BOUND_W = 10;
    localparam int PIX_W   = 8;
    localparam int CLASS_W = 4;
    localparam int LIMIT_W = 12;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAREST_MODE   = 1'd1;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // Colour conversion coefficients
    localparam int COEF_YR   = 299;
    localparam int COEF_YG   = 587;
    localparam int COEF_YB   = 114;
    localparam int ROUND_Y   = 500;
    localparam int COEF_U    = 492;
    localparam int COEF_V    = 877;
    localparam int CHROMA_OFS = 128000;

    // Divide by DIV_BASE as multiply by floor(2^DIV_SHIFT / DIV_BASE), one fix-up
    localparam int DIV_BASE  = 1000;
    localparam int DIV_SHIFT = 29;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / DIV_BASE;
    localparam int NUM_W     = 21;
    localparam int MAG_W     = 19;
    localparam int RECIP_W   = 20;
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam int Q_W       = 10;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [BOUND_W-1:0] y_min;
        logic signed [BOUND_W-1:0] y_max;
        logic signed [BOUND_W-1:0] u_min;
        logic signed [BOUND_W-1:0] u_max;
        logic signed [BOUND_W-1:0] v_min;
        logic signed [BOUND_W-1:0] v_max;
    } t_box;

    typedef struct packed {
        logic                      operation;
        logic [ENTRY_W-1:0]        entry;
        t_box                      box;
        logic signed [BOUND_W-1:0] y_pix;
        logic signed [BOUND_W-1:0] u_pix;
        logic signed [BOUND_W-1:0] v_pix;
    } t_cmd;

    typedef struct packed {
        logic [LIMIT_W-1:0] distance_limit;
        logic               nearest_mode;
    } t_cfg;

    typedef enum logic [1:0] {
        AX_Y,
        AX_U,
        AX_V
    } t_axis;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NUM,
        F_MUL,
        F_FIX,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FETCH,
        B_INIT,
        B_SCAN,
        B_EVAL,
        B_DONE
    } t_back_state;

endpackage

// ===== rtl/core/yuvb_req_if.sv =====
// ----------------------------------------------------------------------------
// YUV box classifier request channel
// Valid/ready channel carrying load and classify requests.
// ----------------------------------------------------------------------------
interface yuvb_req_if;
    import yuvb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [ENTRY_W-1:0]        entry;
    logic signed [BOUND_W-1:0] y_min;
    logic signed [BOUND_W-1:0] y_max;
    logic signed [BOUND_W-1:0] u_min;
    logic signed [BOUND_W-1:0] u_max;
    logic signed [BOUND_W-1:0] v_min;
    logic signed [BOUND_W-1:0] v_max;
    logic [PIX_W-1:0]          red;
    logic [PIX_W-1:0]          green;
    logic [PIX_W-1:0]          blue;

    modport source (
        output valid, operation, entry, y_min, y_max, u_min, u_max, v_min, v_max,
        output red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, operation, entry, y_min, y_max, u_min, u_max, v_min, v_max,
        input  red, green, blue,
        output ready
    );
endinterface

// ===== rtl/core/yuvb_res_if.sv =====
// ----------------------------------------------------------------------------
// YUV box classifier result channel
// Valid/ready channel carrying the chosen class index.
// ----------------------------------------------------------------------------
interface yuvb_res_if;
    import yuvb_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] class_index;

    modport source (
        output valid, class_index,
        input  ready
    );

    modport sink (
        input  valid, class_index,
        output ready
    );
endinterface

// ===== rtl/core/yuvb_front.sv =====
// ----------------------------------------------------------------------------
// YUV box classifier front end
// Accepts requests, converts classify pixels to YUV through one shared
// divide-by-constant datapath, and pushes commands to the queue.
// ----------------------------------------------------------------------------
module yuvb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    yuvb_req_if.sink       i_req,
    output logic           o_push_valid,
    output yuvb_pkg::t_cmd o_push_cmd,
    input  logic           i_push_ready
);
    import yuvb_pkg::*;

    t_front_state r_state, n_state;
    t_axis        r_axis;
    t_cmd         r_cmd;
    logic [PIX_W-1:0] r_red, r_green, r_blue;
    logic             r_neg;
    logic [MAG_W-1:0] r_mag;
    logic [Q_W-1:0]   r_q0;

    logic signed [NUM_W-1:0]   w_num;
    logic [PROD_W-1:0]         w_prod;
    logic [MAG_W:0]            w_rem;
    logic [Q_W-1:0]            w_q;
    logic signed [BOUND_W-1:0] w_res;

    always_comb begin
        case (r_axis)
            AX_Y: begin
                w_num = $signed(NUM_W'(r_red)) * NUM_W'(COEF_YR)
                      + $signed(NUM_W'(r_green)) * NUM_W'(COEF_YG)
                      + $signed(NUM_W'(r_blue)) * NUM_W'(COEF_YB)
                      + NUM_W'(ROUND_Y);
            end
            AX_U: begin
                w_num = NUM_W'(COEF_U) * ($signed(NUM_W'(r_blue)) - NUM_W'(r_cmd.y_pix))
                      + NUM_W'(CHROMA_OFS);
            end
            AX_V: begin
                w_num = NUM_W'(COEF_V) * ($signed(NUM_W'(r_red)) - NUM_W'(r_cmd.y_pix))
                      + NUM_W'(CHROMA_OFS);
            end
            default: begin
                w_num = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(r_mag) * PROD_W'(DIV_RECIP);
    assign w_rem  = (MAG_W+1)'(r_mag) - (MAG_W+1)'(r_q0) * (MAG_W+1)'(DIV_BASE);
    assign w_q    = r_q0 + Q_W'(w_rem >= (MAG_W+1)'(DIV_BASE));
    assign w_res  = r_neg ? -$signed(BOUND_W'(w_q)) : $signed(BOUND_W'(w_q));

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.operation == OP_CLASSIFY) ? F_NUM : F_PUSH;
                end
            end
            F_NUM: begin
                n_state = F_MUL;
            end
            F_MUL: begin
                n_state = F_FIX;
            end
            F_FIX: begin
                n_state = (r_axis == AX_V) ? F_PUSH : F_NUM;
            end
            F_PUSH: begin
                if (i_push_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_comb begin
        i_req.ready  = (r_state == F_IDLE);
        o_push_valid = (r_state == F_PUSH);
    end

    assign o_push_cmd = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_cmd.operation <= i_req.operation;
                r_cmd.entry     <= i_req.entry;
                r_cmd.box.y_min <= i_req.y_min;
                r_cmd.box.y_max <= i_req.y_max;
                r_cmd.box.u_min <= i_req.u_min;
                r_cmd.box.u_max <= i_req.u_max;
                r_cmd.box.v_min <= i_req.v_min;
                r_cmd.box.v_max <= i_req.v_max;
                r_red   <= i_req.red;
                r_green <= i_req.green;
                r_blue  <= i_req.blue;
                r_axis  <= AX_Y;
            end
            F_NUM: begin
                r_neg <= w_num[NUM_W-1];
                r_mag <= MAG_W'(w_num[NUM_W-1] ? -w_num : w_num);
            end
            F_MUL: begin
                r_q0 <= Q_W'(w_prod >> DIV_SHIFT);
            end
            F_FIX: begin
                case (r_axis)
                    AX_Y: begin
                        r_cmd.y_pix <= w_res;
                        r_axis      <= AX_U;
                    end
                    AX_U: begin
                        r_cmd.u_pix <= w_res;
                        r_axis      <= AX_V;
                    end
                    default: begin
                        r_cmd.v_pix <= w_res;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== rtl/core/yuvb_queue.sv =====
// ----------------------------------------------------------------------------
// YUV box classifier command queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module yuvb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  yuvb_pkg::t_cmd i_push_cmd,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output yuvb_pkg::t_cmd o_pop_cmd,
    input  logic           i_pop_ready
);
    import yuvb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end
endmodule

// ===== rtl/core/yuvb_back.sv =====
// ----------------------------------------------------------------------------
// YUV box classifier back end
// Holds the box table, walks the boxes for each pixel with one shared
// sampling unit, and registers the chosen class for the result channel.
// ----------------------------------------------------------------------------
module yuvb_back #(
    parameter int NUM_COLORS  = yuvb_pkg::NUM_COLORS_DEF,
    parameter int SAMPLE_STEP = yuvb_pkg::SAMPLE_STEP_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  yuvb_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  yuvb_pkg::t_cmd i_cmd,
    output logic           o_cmd_ready,
    yuvb_res_if.source     o_res
);
    import yuvb_pkg::*;

    localparam int IW   = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
    localparam int T_W  = BOUND_W + 2;
    localparam int D_W  = BOUND_W;
    localparam int S_W  = LIMIT_W;

    function automatic logic [D_W-1:0] f_absd(input logic signed [T_W-1:0] a,
                                              input logic signed [T_W-1:0] b);
        logic signed [T_W-1:0] d;
        d = a - b;
        return D_W'(d < 0 ? -d : d);
    endfunction

    function automatic logic [D_W-1:0] f_min(input logic [D_W-1:0] a,
                                             input logic [D_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    t_back_state r_state, n_state;
    t_box        r_table [NUM_COLORS];
    t_box        r_box;
    logic signed [BOUND_W-1:0] r_py, r_pu, r_pv;
    logic signed [T_W-1:0]     r_ty, r_tu, r_tv;
    logic [D_W-1:0]            r_dy, r_du, r_dv;
    logic [IW-1:0]             r_bidx, r_class;
    logic [S_W-1:0]            r_best;
    logic                      r_inside;
    logic                      r_out_valid;
    logic [CLASS_W-1:0]        r_out_class;

    logic w_accept, w_load_hit, w_inside, w_last, w_out_free;
    logic w_act_y, w_act_u, w_act_v;
    logic w_sy, w_su, w_sv, w_any, w_take;
    logic [S_W-1:0] w_fy, w_fu, w_fv, w_d;

    assign w_accept   = i_cmd_valid && o_cmd_ready;
    assign w_load_hit = ({1'b0, i_cmd.entry} < (ENTRY_W+1)'(NUM_COLORS));
    assign w_last     = (r_bidx == IW'(NUM_COLORS - 1));
    assign w_out_free = !r_out_valid || o_res.ready;

    assign w_inside = (r_py >= r_box.y_min) && (r_py <= r_box.y_max)
                   && (r_pu >= r_box.u_min) && (r_pu <= r_box.u_max)
                   && (r_pv >= r_box.v_min) && (r_pv <= r_box.v_max);

    assign w_act_y = (r_ty <= T_W'(r_box.y_max));
    assign w_act_u = (r_tu <= T_W'(r_box.u_max));
    assign w_act_v = (r_tv <= T_W'(r_box.v_max));

    // Face distances: distance to the face plane plus in-plane sample distances
    always_comb begin
        w_sy = (r_box.y_min <= r_box.y_max);
        w_su = (r_box.u_min <= r_box.u_max);
        w_sv = (r_box.v_min <= r_box.v_max);
        w_fy = S_W'(f_min(f_absd(T_W'(r_py), T_W'(r_box.y_min)),
                          f_absd(T_W'(r_py), T_W'(r_box.y_max))))
             + S_W'(r_du) + S_W'(r_dv);
        w_fu = S_W'(f_min(f_absd(T_W'(r_pu), T_W'(r_box.u_min)),
                          f_absd(T_W'(r_pu), T_W'(r_box.u_max))))
             + S_W'(r_dy) + S_W'(r_dv);
        w_fv = S_W'(f_min(f_absd(T_W'(r_pv), T_W'(r_box.v_min)),
                          f_absd(T_W'(r_pv), T_W'(r_box.v_max))))
             + S_W'(r_dy) + S_W'(r_du);
        w_d   = '1;
        w_any = 1'b0;
        if (w_su && w_sv) begin
            w_d   = w_fy;
            w_any = 1'b1;
        end
        if (w_sy && w_sv && (w_fu < w_d)) begin
            w_d = w_fu;
        end
        if (w_sy && w_sv) begin
            w_any = 1'b1;
        end
        if (w_sy && w_su && (w_fv < w_d)) begin
            w_d = w_fv;
        end
        if (w_sy && w_su) begin
            w_any = 1'b1;
        end
        w_take = i_cfg.nearest_mode && w_any && (w_d < r_best)
              && (w_d <= i_cfg.distance_limit);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid && (i_cmd.operation == OP_CLASSIFY)) begin
                    n_state = B_FETCH;
                end
            end
            B_FETCH: begin
                n_state = B_INIT;
            end
            B_INIT: begin
                n_state = (w_inside || !i_cfg.nearest_mode) ? B_EVAL : B_SCAN;
            end
            B_SCAN: begin
                if (!w_act_y && !w_act_u && !w_act_v) begin
                    n_state = B_EVAL;
                end
            end
            B_EVAL: begin
                n_state = w_last ? B_DONE : B_FETCH;
            end
            B_DONE: begin
                if (w_out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_ready       = (r_state == B_IDLE);
        o_res.valid       = r_out_valid;
        o_res.class_index = r_out_class;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Box table: written by load commands, read one box per step
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_cmd.operation == OP_LOAD) && w_load_hit) begin
            r_table[i_cmd.entry[IW-1:0]] <= i_cmd.box;
        end
        if (r_state == B_FETCH) begin
            r_box <= r_table[r_bidx];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_py    <= i_cmd.y_pix;
                r_pu    <= i_cmd.u_pix;
                r_pv    <= i_cmd.v_pix;
                r_bidx  <= '0;
                r_class <= '0;
                r_best  <= '1;
            end
            B_INIT: begin
                r_inside <= w_inside;
                r_ty     <= T_W'(r_box.y_min);
                r_tu     <= T_W'(r_box.u_min);
                r_tv     <= T_W'(r_box.v_min);
                r_dy     <= '1;
                r_du     <= '1;
                r_dv     <= '1;
            end
            B_SCAN: begin
                if (w_act_y) begin
                    r_dy <= f_min(r_dy, f_absd(T_W'(r_py), r_ty));
                    r_ty <= r_ty + T_W'(SAMPLE_STEP);
                end
                if (w_act_u) begin
                    r_du <= f_min(r_du, f_absd(T_W'(r_pu), r_tu));
                    r_tu <= r_tu + T_W'(SAMPLE_STEP);
                end
                if (w_act_v) begin
                    r_dv <= f_min(r_dv, f_absd(T_W'(r_pv), r_tv));
                    r_tv <= r_tv + T_W'(SAMPLE_STEP);
                end
            end
            B_EVAL: begin
                if (r_inside) begin
                    r_class <= r_bidx;
                    r_best  <= '0;
                end else if (w_take) begin
                    r_class <= r_bidx;
                    r_best  <= w_d;
                end
                r_bidx <= r_bidx + 1'b1;
            end
            B_DONE: begin
                if (w_out_free) begin
                    r_out_class <= CLASS_W'(r_class);
                end
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== rtl/core/yuv_box_nearest_color_classifier.sv =====
// ----------------------------------------------------------------------------
// YUV box nearest colour classifier
// Colour box table with containment and nearest-box classification.
// ----------------------------------------------------------------------------
// A load request writes one colour box (inclusive YUV bounds) to table entry
// `entry`; entries at or above NUM_COLORS are dropped and a load gives no
// result. A classify request converts its RGB pixel to integer YUV and returns
// one class index: the last box containing the pixel, otherwise (in nearest
// mode) the box whose sampled face points lie closest in L1 distance, if that
// distance is within distance_limit, the earlier box winning a tie; 0 when
// nothing matches. Load every entry before classifying. The front end does the
// YUV conversion of a classify in three passes through one divide-by-1000
// unit, and a two-entry queue lets it run ahead of the back end. The back end
// visits the boxes in turn through fetch, init and eval states and, in nearest
// mode for a box not containing the pixel, a scan state that takes
// ceil((max-min+1)/SAMPLE_STEP) samples on each axis until the longest axis is
// done, from a single shared sampling unit. Results sit in an output register;
// the back end moves on once that register is free. Write configuration only
// while idle.
// ----------------------------------------------------------------------------
module yuv_box_nearest_color_classifier #(
    parameter int NUM_COLORS  = yuvb_pkg::NUM_COLORS_DEF,
    parameter int SAMPLE_STEP = yuvb_pkg::SAMPLE_STEP_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    yuvb_req_if.sink                          i_req,
    yuvb_res_if.source                        o_res,
    input  logic                              i_cfg_wr_en,
    input  logic [yuvb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [yuvb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import yuvb_pkg::*;

    t_cfg r_cfg;
    logic w_push_valid, w_push_ready, w_pop_valid, w_pop_ready;
    t_cmd w_push_cmd, w_pop_cmd;

    // Configuration registers: hold until rewritten
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance_limit <= '0;
            r_cfg.nearest_mode   <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DISTANCE_LIMIT: begin
                    r_cfg.distance_limit <= LIMIT_W'(i_cfg_wdata);
                end
                CFG_NEAREST_MODE: begin
                    r_cfg.nearest_mode <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end: take requests, convert pixels to YUV
    yuvb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (w_push_valid),
        .o_push_cmd   (w_push_cmd),
        .i_push_ready (w_push_ready)
    );

    // Decouple conversion from the box walk
    yuvb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_cmd   (w_push_cmd),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_cmd    (w_pop_cmd),
        .i_pop_ready  (w_pop_ready)
    );

    // Back end: box table, box walk and result register
    yuvb_back #(
        .NUM_COLORS  (NUM_COLORS),
        .SAMPLE_STEP (SAMPLE_STEP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_pop_valid),
        .i_cmd       (w_pop_cmd),
        .o_cmd_ready (w_pop_ready),
        .o_res       (o_res)
    );
endmodule

// ===== rtl/core/yuvb_checker.sv =====
// ----------------------------------------------------------------------------
// YUV box classifier port checker
// Watches the classifier ports for spurious results, class range and handshake slips.
// ----------------------------------------------------------------------------
`include "yuv_box_nearest_color_classifier_macros.svh"

module yuvb_checker #(
    parameter int NUM_COLORS = yuvb_pkg::NUM_COLORS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_operation,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [yuvb_pkg::CLASS_W-1:0] i_out_class
);
    import yuvb_pkg::*;

    logic [2:0] r_pend;
    logic       w_in_cls, w_out_acc;

    assign w_in_cls  = i_in_valid && i_in_ready && (i_in_operation == OP_CLASSIFY);
    assign w_out_acc = i_out_valid && i_out_ready;

    // Count classify requests still owed a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_cls && !w_out_acc) begin
            r_pend <= r_pend + 1'b1;
        end else if (w_out_acc && !w_in_cls) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    `YUVB_ASSERT_IMP(a_no_spurious_result, i_clk, i_rst_n, w_out_acc, r_pend != 3'd0, "result without pending classify")
    `YUVB_ASSERT_IMP(a_class_in_range, i_clk, i_rst_n, i_out_valid, ({1'b0, i_out_class} < (CLASS_W+1)'(NUM_COLORS)), "class index beyond table")
    `YUVB_ASSERT_NXT_RST(a_reset_clears_result, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")
    `YUVB_ASSERT_NXT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_class), "stalled result dropped or changed")
endmodule

bind yuv_box_nearest_color_classifier yuvb_checker #(
    .NUM_COLORS (NUM_COLORS)
) u_yuvb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_in_operation (i_req.operation),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_class    (o_res.class_index)
);

// ===== bench/tb_yuv_box_nearest_color_classifier.sv =====
// ----------------------------------------------------------------------------
// YUV box classifier testbench
// Loads colour boxes, classifies random and corner pixels under several
// register settings and idling patterns, and checks every class index
// against a behavioural prediction kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_yuv_box_nearest_color_classifier;
    import yuvb_pkg::*;

    class class_scoreboard;
        int                 box_lo [NUM_COLORS_DEF][3];
        int                 box_hi [NUM_COLORS_DEF][3];
        logic [LIMIT_W-1:0] limit_q;
        logic               nearest_q;
        logic [CLASS_W-1:0] pending_class [$];
        int                 errors;

        function new();
            for (int i = 0; i < NUM_COLORS_DEF; i++) begin
                for (int a = 0; a < 3; a++) begin
                    box_lo[i][a] = 0;
                    box_hi[i][a] = 0;
                end
            end
            limit_q   = '0;
            nearest_q = 1'b1;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_DISTANCE_LIMIT) limit_q = val[LIMIT_W-1:0];
            else if (idx == CFG_NEAREST_MODE) nearest_q = val[0];
        endfunction

        // Distance to the closest sampled coordinate on one axis; ok low when the extent is empty.
        function int axis_near(int lo, int hi, int p, output bit ok);
            int best;
            best = 32'h7FFFFFFF;
            ok   = (lo <= hi);
            for (int t = lo; t <= hi; t += SAMPLE_STEP_DEF) begin
                if ((p > t ? p - t : t - p) < best) best = (p > t ? p - t : t - p);
            end
            return best;
        endfunction

        function int absd(int a, int b);
            return a > b ? a - b : b - a;
        endfunction

        function int minv(int a, int b);
            return a < b ? a : b;
        endfunction

        function logic [CLASS_W-1:0] nearest_class(int r, int g, int b);
            int  pix [3];
            int  d [3];
            bit  ok [3];
            int  best_d, near_d;
            bit  inbox, any;
            logic [CLASS_W-1:0] idx;
            pix[0] = (COEF_YR * r + COEF_YG * g + COEF_YB * b + ROUND_Y) / DIV_BASE;
            pix[1] = (COEF_U * (b - pix[0]) + CHROMA_OFS) / DIV_BASE;
            pix[2] = (COEF_V * (r - pix[0]) + CHROMA_OFS) / DIV_BASE;
            best_d = 32'h7FFFFFFF;
            idx    = '0;
            for (int i = 0; i < NUM_COLORS_DEF; i++) begin
                inbox = 1'b1;
                for (int a = 0; a < 3; a++) begin
                    if (pix[a] < box_lo[i][a] || pix[a] > box_hi[i][a]) inbox = 1'b0;
                    d[a] = axis_near(box_lo[i][a], box_hi[i][a], pix[a], ok[a]);
                end
                if (inbox) begin
                    idx    = i[CLASS_W-1:0];
                    best_d = 0;
                end else if (nearest_q) begin
                    near_d = 32'h7FFFFFFF;
                    any    = 1'b0;
                    // each face fixes one axis at a bound and samples the other two
                    for (int a = 0; a < 3; a++) begin
                        if (ok[(a + 1) % 3] && ok[(a + 2) % 3]) begin
                            near_d = minv(near_d, minv(absd(pix[a], box_lo[i][a]),
                                                       absd(pix[a], box_hi[i][a]))
                                                  + d[(a + 1) % 3] + d[(a + 2) % 3]);
                            any = 1'b1;
                        end
                    end
                    if (any && near_d < best_d && near_d <= int'(limit_q)) begin
                        idx    = i[CLASS_W-1:0];
                        best_d = near_d;
                    end
                end
            end
            return idx;
        endfunction

        function void note_request(logic op, logic [ENTRY_W-1:0] ent, t_box bx,
                                   int r, int g, int b);
            if (op == OP_LOAD) begin
                if (ent < NUM_COLORS_DEF) begin
                    box_lo[ent][0] = bx.y_min;  box_hi[ent][0] = bx.y_max;
                    box_lo[ent][1] = bx.u_min;  box_hi[ent][1] = bx.u_max;
                    box_lo[ent][2] = bx.v_min;  box_hi[ent][2] = bx.v_max;
                end
            end else begin
                pending_class.push_back(nearest_class(r, g, b));
            end
        endfunction

        function void check_class(logic [CLASS_W-1:0] got);
            logic [CLASS_W-1:0] want;
            if (pending_class.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, got);
                errors++;
            end else begin
                want = pending_class.pop_front();
                if (want !== got) begin
                    $display("%0t: class_index mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 1500;   // longest classify in flight, with margin
    localparam int  HOLD_CYCLES = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    yuvb_req_if req_ch ();
    yuvb_res_if res_ch ();

    class_scoreboard sb;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req    = 1'b0;
    int  cycle_cnt   = 0;

    yuv_box_nearest_color_classifier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Drive every request input to a known value before the first edge.
    initial begin
        req_ch.valid = 1'b0;  req_ch.operation = OP_LOAD;  req_ch.entry = '0;
        req_ch.y_min = '0;    req_ch.y_max = '0;    req_ch.u_min = '0;
        req_ch.u_max = '0;    req_ch.v_min = '0;    req_ch.v_max = '0;
        req_ch.red = '0;      req_ch.green = '0;    req_ch.blue = '0;
        res_ch.ready = 1'b0;
        sb = new();
    end

    // Watchdog: give up well beyond the slowest legal run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Note every accepted request in the scoreboard, in acceptance order.
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.operation, req_ch.entry,
                            '{req_ch.y_min, req_ch.y_max, req_ch.u_min,
                              req_ch.u_max, req_ch.v_min, req_ch.v_max},
                            req_ch.red, req_ch.green, req_ch.blue);
    end

    // Check every accepted result against the oldest pending class.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_class(res_ch.class_index);
    end

    // Receiver: random stalls, or one long hold-off on request so the
    // back end fills up and the request channel backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one request and hold it until accepted; idle afterwards at random.
    task automatic send_request(logic op, logic [ENTRY_W-1:0] ent, t_box bx,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.entry     <= ent;
        req_ch.y_min <= bx.y_min;  req_ch.y_max <= bx.y_max;
        req_ch.u_min <= bx.u_min;  req_ch.u_max <= bx.u_max;
        req_ch.v_min <= bx.v_min;  req_ch.v_max <= bx.v_max;
        req_ch.red   <= r;  req_ch.green <= g;  req_ch.blue <= b;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic load_box(logic [ENTRY_W-1:0] ent, t_box bx);
        send_request(OP_LOAD, ent, bx, PIX_W'($urandom), PIX_W'($urandom),
                     PIX_W'($urandom));
    endtask

    task automatic classify(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send_request(OP_CLASSIFY, ENTRY_W'($urandom), t_box'({$urandom, $urandom}),
                     r, g, b);
    endtask

    // Drop valid, wait for every pending class, then let any load settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_class.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges; block is idle here.
    task automatic write_regs(logic [LIMIT_W-1:0] lim, logic mode);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_DISTANCE_LIMIT;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        sb.set_reg(CFG_DISTANCE_LIMIT, lim);
        i_cfg_index <= CFG_NEAREST_MODE;
        i_cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, mode};
        @(posedge i_clk);
        sb.set_reg(CFG_NEAREST_MODE, mode);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly compact boxes around the reachable YUV range, some raw bits.
    function automatic t_box rand_box();
        t_box bx;
        int   c, w;
        if ($urandom_range(9) == 0) begin
            bx = t_box'({$urandom, $urandom});
        end else begin
            c = $urandom_range(0, 255);  w = $urandom_range(0, 60);
            bx.y_min = BOUND_W'(c - w);  bx.y_max = BOUND_W'(c + w);
            c = $urandom_range(0, 255);  w = $urandom_range(0, 60);
            bx.u_min = BOUND_W'(c - w);  bx.u_max = BOUND_W'(c + w);
            c = $urandom_range(0, 446) - 95;  w = $urandom_range(0, 60);
            bx.v_min = BOUND_W'(c - w);  bx.v_max = BOUND_W'(c + w);
        end
        return bx;
    endfunction

    initial begin
        logic [LIMIT_W-1:0] lim_set [6];
        logic               mode_set [6];
        t_box               bx;
        int                 sub;

        lim_set  = '{12'd0, 12'd4095, 12'd0, 12'd40, 12'd4095, 12'd150};
        mode_set = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

        // Hold reset, then release it on an edge.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill the table first, covering extreme and empty boxes.
        write_regs(12'd60, 1'b1);
        load_box(4'd0,  '{-10'sd512, 10'sd511, -10'sd512, 10'sd511, -10'sd512, 10'sd511});
        load_box(4'd1,  '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0});
        load_box(4'd2,  '{10'sd200, 10'sd100, 10'sd0, 10'sd255, 10'sd0, 10'sd255});
        load_box(4'd3,  '{10'sd511, 10'sd511, -10'sd512, -10'sd512, 10'sd511, 10'sd511});
        load_box(4'd4,  '{10'sd250, 10'sd255, 10'sd120, 10'sd135, 10'sd120, 10'sd135});
        load_box(4'd5,  '{10'sd140, 10'sd160, 10'sd40, 10'sd80, -10'sd95, -10'sd1});
        load_box(4'd6,  '{10'sd0, 10'sd5, 10'sd120, 10'sd135, 10'sd120, 10'sd135});
        load_box(4'd7,  '{10'sd60, 10'sd90, 10'sd200, 10'sd255, 10'sd50, 10'sd110});
        load_box(4'd8,  '{10'sd70, 10'sd80, 10'sd80, 10'sd70, 10'sd300, 10'sd351});
        load_box(4'd9,  '{10'sd10, 10'sd500, 10'sd10, 10'sd500, 10'sd400, 10'sd300});
        // out-of-range entries: dropped
        load_box(4'd10, '{-10'sd512, 10'sd511, -10'sd512, 10'sd511, -10'sd512, 10'sd511});
        load_box(4'd15, '{-10'sd512, 10'sd511, -10'sd512, 10'sd511, -10'sd512, 10'sd511});
        classify(8'd0,   8'd0,   8'd0);
        classify(8'd255, 8'd255, 8'd255);
        classify(8'd255, 8'd0,   8'd0);
        classify(8'd0,   8'd255, 8'd0);
        classify(8'd0,   8'd0,   8'd255);
        classify(8'd255, 8'd255, 8'd0);
        classify(8'd0,   8'd255, 8'd255);
        classify(8'd128, 8'd128, 8'd128);
        drain();
        write_regs(12'd4095, 1'b0);
        classify(8'd0,   8'd255, 8'd0);
        classify(8'd255, 8'd0,   8'd255);
        drain();

        // Random: three idling patterns, two register settings each.
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 6  : (ph == 1) ? 51 : 0;
            rx_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 6  : 0;
            for (int half = 0; half < 2; half++) begin
                sub = ph * 2 + half;
                write_regs((sub == 5) ? LIMIT_W'($urandom_range(5, 200)) : lim_set[sub],
                           mode_set[sub]);
                if (ph == 2 && half == 0) hold_req = 1'b1;
                for (int n = 0; n < 20; n++) begin
                    if ($urandom_range(4) == 0) begin
                        bx = rand_box();
                        // the odd load to a dropped entry
                        load_box(ENTRY_W'(($urandom_range(7) == 0) ? $urandom_range(10, 15)
                                                                   : $urandom_range(0, 9)),
                                 bx);
                    end else begin
                        classify(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
                    end
                end
                drain();
            end
        end

        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
